### rtl/rmq_pkg.sv
// Shared types, widths and constants for the rotation matrix to quaternion unit.
// No dependencies; every other file imports this package.
package rmq_pkg;

	// Fixed-point format of every field
	localparam int FRAC_BITS = 16;
	localparam int FIELD_W   = 18;

	// Trace and radicand arithmetic
	localparam int SUM_W  = FIELD_W + 3;
	localparam int RAD_W  = FIELD_W + 1;
	localparam int NSQ_W  = RAD_W + FRAC_BITS;
	localparam int ROOT_W = (NSQ_W + 1) / 2;
	localparam int SQ_STEPS = ROOT_W;

	// Quotient arithmetic
	localparam int DIFF_W  = FIELD_W + 1;
	localparam int NUM_W   = DIFF_W + FRAC_BITS;
	localparam int DEN_W   = ROOT_W + 1;
	localparam int QUO_W   = FIELD_W;
	localparam int CMP_W   = DEN_W + QUO_W;
	localparam int DV_STEPS = QUO_W;
	localparam int LANES   = 3;

	localparam logic signed [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
	localparam logic signed [FIELD_W-1:0] SAT_MIN = {1'b1, {(FIELD_W-1){1'b0}}};
	localparam logic signed [SUM_W-1:0]   ONE     = SUM_W'(1) << FRAC_BITS;

	typedef logic signed [FIELD_W-1:0] fix_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	// Component that takes the half root
	typedef enum logic [3:0] {
		BR_W = 4'b0001,
		BR_X = 4'b0010,
		BR_Y = 4'b0100,
		BR_Z = 4'b1000
	} branch_t;

	// Branch and off-diagonal terms, in ascending order of the other three slots
	typedef struct packed {
		branch_t br;
		diff_t   d0;
		diff_t   d1;
		diff_t   d2;
	} side_t;

	// Per-item control through the divider stages
	typedef struct packed {
		branch_t                          br;
		logic [ROOT_W-1:0]                root;
		logic [DEN_W-1:0]                 den;
		logic                             zr;
		logic [LANES-1:0]                 neg;
		logic [LANES-1:0]                 ovf;
		logic [LANES-1:0][QUO_W-1:0]      quo;
	} dv_ctl_t;

endpackage

### rtl/rmq_ifs.sv
// Valid/ready channel interfaces for the matrix input and the quaternion output.
// Depends on rmq_pkg.
interface rmq_mat_if import rmq_pkg::*; ();
	logic valid;
	logic ready;
	fix_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

interface rmq_quat_if import rmq_pkg::*; ();
	logic valid;
	logic ready;
	fix_t quat_w, quat_x, quat_y, quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

### rtl/rmq_prep.sv
// First stage: trace, branch choice, clamped radicand and off-diagonal terms.
// Depends on rmq_pkg.
module rmq_prep import rmq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  fix_t              m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic              out_vld,
	output logic [RAD_W-1:0]  rad,
	output side_t             side
);

	logic signed [SUM_W-1:0] a00, a11, a22, tr, s;
	side_t                   side_c;
	logic [RAD_W-1:0]        rad_c;
	logic                    vld_s1;
	logic [RAD_W-1:0]        rad_s1;
	side_t                   side_s1;

	assign a00 = SUM_W'(m00);
	assign a11 = SUM_W'(m11);
	assign a22 = SUM_W'(m22);
	assign tr  = a00 + a11 + a22;

	// Pick the branch and form its radicand and terms
	always_comb begin
		if (tr > 0) begin
			s         = tr + ONE;
			side_c.br = BR_W;
			side_c.d0 = DIFF_W'(m21) - DIFF_W'(m12);
			side_c.d1 = DIFF_W'(m02) - DIFF_W'(m20);
			side_c.d2 = DIFF_W'(m10) - DIFF_W'(m01);
		end else if (a11 > a00 && a11 > a22) begin
			s         = a11 - a00 - a22 + ONE;
			side_c.br = BR_Y;
			side_c.d0 = DIFF_W'(m02) - DIFF_W'(m20);
			side_c.d1 = DIFF_W'(m10) + DIFF_W'(m01);
			side_c.d2 = DIFF_W'(m21) + DIFF_W'(m12);
		end else if (a22 > a00) begin
			s         = a22 - a00 - a11 + ONE;
			side_c.br = BR_Z;
			side_c.d0 = DIFF_W'(m10) - DIFF_W'(m01);
			side_c.d1 = DIFF_W'(m02) + DIFF_W'(m20);
			side_c.d2 = DIFF_W'(m21) + DIFF_W'(m12);
		end else begin
			s         = a00 - a11 - a22 + ONE;
			side_c.br = BR_X;
			side_c.d0 = DIFF_W'(m21) - DIFF_W'(m12);
			side_c.d1 = DIFF_W'(m10) + DIFF_W'(m01);
			side_c.d2 = DIFF_W'(m02) + DIFF_W'(m20);
		end
		// Clamp a negative radicand to zero
		if (s <= 0) begin
			rad_c = '0;
		end else begin
			rad_c = s[RAD_W-1:0];
		end
	end

	// Stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s1  <= rad_c;
			side_s1 <= side_c;
		end
	end

	assign out_vld = vld_s1;
	assign rad     = rad_s1;
	assign side    = side_s1;

endmodule

### rtl/rmq_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, of rad << FRAC_BITS.
// Depends on rmq_pkg.
module rmq_sqrt_pipe import rmq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  rad,
	input  side_t             in_side,
	output logic              out_vld,
	output logic [ROOT_W-1:0] root,
	output side_t             out_side
);

	logic [NSQ_W-1:0]    rem_s  [SQ_STEPS];
	logic [NSQ_W-1:0]    res_s  [SQ_STEPS];
	side_t               side_s [SQ_STEPS];
	logic [SQ_STEPS-1:0] vld_s;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
		localparam logic [NSQ_W-1:0] BIT = NSQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [NSQ_W-1:0] rem_i, res_i, trial, rem_o, res_o;
		side_t            side_i;
		logic             vld_i;

		if (k == 0) begin : g_first
			assign rem_i  = {rad, {FRAC_BITS{1'b0}}};
			assign res_i  = '0;
			assign side_i = in_side;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign res_i  = res_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		// Try the next root bit
		always_comb begin
			trial = res_i + BIT;
			if (rem_i >= trial) begin
				rem_o = rem_i - trial;
				res_o = (res_i >> 1) + BIT;
			end else begin
				rem_o = rem_i;
				res_o = res_i >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k]  <= rem_o;
				res_s[k]  <= res_o;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_vld  = vld_s[SQ_STEPS-1];
	assign root     = res_s[SQ_STEPS-1][ROOT_W-1:0];
	assign out_side = side_s[SQ_STEPS-1];

endmodule

### rtl/rmq_div_pipe.sv
// Three-lane pipelined restoring divider: |d| << FRAC_BITS over 2*root,
// one quotient bit per stage, with an overflow check up front. Depends on rmq_pkg.
module rmq_div_pipe import rmq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  logic [ROOT_W-1:0] root,
	input  side_t             in_side,
	output logic              out_vld,
	output dv_ctl_t           out_ctl
);

	diff_t                   d_c   [LANES];
	logic [DIFF_W-1:0]       mag_c [LANES];
	logic [NUM_W-1:0]        num_c [LANES];
	dv_ctl_t                 ctl_c;

	logic                    vld_s1;
	dv_ctl_t                 ctl_s1;
	logic [NUM_W-1:0]        rem_s1 [LANES];

	logic [NUM_W-1:0]        rem_s [DV_STEPS][LANES];
	dv_ctl_t                 ctl_s [DV_STEPS];
	logic [DV_STEPS-1:0]     vld_s;

	assign d_c[0] = in_side.d0;
	assign d_c[1] = in_side.d1;
	assign d_c[2] = in_side.d2;

	// Signs, magnitudes and overflow check
	always_comb begin
		ctl_c      = '0;
		ctl_c.br   = in_side.br;
		ctl_c.root = root;
		ctl_c.den  = {root, 1'b0};
		ctl_c.zr   = (root == '0);
		for (int l = 0; l < LANES; l++) begin
			ctl_c.neg[l] = d_c[l][DIFF_W-1];
			mag_c[l]     = d_c[l][DIFF_W-1] ? DIFF_W'(-d_c[l]) : DIFF_W'(d_c[l]);
			num_c[l]     = {mag_c[l], {FRAC_BITS{1'b0}}};
			ctl_c.ovf[l] = (CMP_W'(num_c[l]) >= (CMP_W'({root, 1'b0}) << QUO_W));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_c;
			for (int l = 0; l < LANES; l++) begin
				rem_s1[l] <= num_c[l];
			end
		end
	end

	for (genvar k = 0; k < DV_STEPS; k++) begin : g_stage
		localparam int QB = DV_STEPS - 1 - k;
		logic [NUM_W-1:0] rem_i [LANES];
		logic [NUM_W-1:0] rem_o [LANES];
		logic [CMP_W-1:0] dsh;
		dv_ctl_t          ctl_i, ctl_o;
		logic             vld_i;

		if (k == 0) begin : g_first
			assign rem_i = rem_s1;
			assign ctl_i = ctl_s1;
			assign vld_i = vld_s1;
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign ctl_i = ctl_s[k-1];
			assign vld_i = vld_s[k-1];
		end

		// Subtract the shifted divisor where it fits
		always_comb begin
			dsh   = CMP_W'(ctl_i.den) << QB;
			ctl_o = ctl_i;
			for (int l = 0; l < LANES; l++) begin
				if (CMP_W'(rem_i[l]) >= dsh) begin
					rem_o[l]         = rem_i[l] - dsh[NUM_W-1:0];
					ctl_o.quo[l][QB] = 1'b1;
				end else begin
					rem_o[l]         = rem_i[l];
					ctl_o.quo[l][QB] = 1'b0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_s[k] <= ctl_o;
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= rem_o[l];
				end
			end
		end
	end

	assign out_vld = vld_s[DV_STEPS-1];
	assign out_ctl = ctl_s[DV_STEPS-1];

endmodule

### rtl/rotation_matrix_to_quaternion_unit.sv
// Top level of the rotation matrix to quaternion unit (Shepperd's method).
// Depends on rmq_pkg, rmq_ifs, rmq_prep, rmq_sqrt_pipe and rmq_div_pipe.
//
// Usage:
//   mat  - sink channel: nine signed Q2.16 matrix entries, one matrix per transfer.
//   quat - source channel: quaternion w, x, y, z in signed Q2.16, saturated.
//   Each matrix gives exactly one quaternion, in order.
// Pipeline from input transfer to quat.valid (stages as built for Q2.16): one
//   prep stage, one stage per root bit, one divider setup stage, one stage per
//   quotient bit, one output register.
// Throughput: one matrix per cycle when not stalled; the bit-serial root and divider
//   stages are fully pipelined and the three quotients run in parallel lanes.
// Reset: arst_n clears every valid bit; no result is shown after reset until
//   a new matrix has gone through.
// Stall: when quat.ready is low with a result waiting, the whole pipeline
//   holds and mat.ready drops; empty slots do not squeeze out. As soon as the
//   output register is empty or being taken, mat.ready is high again.
//
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rmq_mat_if.sink    mat,
	rmq_quat_if.source quat
);

	logic              adv;
	logic              pp_vld;
	logic [RAD_W-1:0]  pp_rad;
	side_t             pp_side;
	logic              sq_vld;
	logic [ROOT_W-1:0] sq_root;
	side_t             sq_side;
	logic              dv_vld;
	dv_ctl_t           dv_ctl;

	fix_t              val_c [LANES];
	fix_t              half_c;
	fix_t              w_c, x_c, y_c, z_c;
	logic              vld_q;
	fix_t              w_q, x_q, y_q, z_q;

	// Advance the whole pipeline whenever the output slot frees up
	assign adv       = !vld_q || quat.ready;
	assign mat.ready = adv;

	rmq_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (mat.valid),
		.m00     (mat.m00), .m01 (mat.m01), .m02 (mat.m02),
		.m10     (mat.m10), .m11 (mat.m11), .m12 (mat.m12),
		.m20     (mat.m20), .m21 (mat.m21), .m22 (mat.m22),
		.out_vld (pp_vld),
		.rad     (pp_rad),
		.side    (pp_side)
	);

	rmq_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (pp_vld),
		.rad      (pp_rad),
		.in_side  (pp_side),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	rmq_div_pipe u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (sq_vld),
		.root    (sq_root),
		.in_side (sq_side),
		.out_vld (dv_vld),
		.out_ctl (dv_ctl)
	);

	// Apply signs and saturate each quotient; a zero root forces zero
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (dv_ctl.zr) begin
				val_c[l] = '0;
			end else if (dv_ctl.ovf[l]) begin
				val_c[l] = dv_ctl.neg[l] ? SAT_MIN : SAT_MAX;
			end else if (dv_ctl.neg[l]) begin
				if (dv_ctl.quo[l] > QUO_W'(SAT_MIN)) begin
					val_c[l] = SAT_MIN;
				end else begin
					val_c[l] = FIELD_W'(-dv_ctl.quo[l]);
				end
			end else begin
				if (dv_ctl.quo[l] > QUO_W'(SAT_MAX)) begin
					val_c[l] = SAT_MAX;
				end else begin
					val_c[l] = FIELD_W'(dv_ctl.quo[l]);
				end
			end
		end
		half_c = FIELD_W'(dv_ctl.root >> 1);
	end

	// Route the half root and the three quotients to their components
	always_comb begin
		case (dv_ctl.br)
			BR_X: begin
				w_c = val_c[0]; x_c = half_c;   y_c = val_c[1]; z_c = val_c[2];
			end
			BR_Y: begin
				w_c = val_c[0]; x_c = val_c[1]; y_c = half_c;   z_c = val_c[2];
			end
			BR_Z: begin
				w_c = val_c[0]; x_c = val_c[1]; y_c = val_c[2]; z_c = half_c;
			end
			default: begin
				w_c = half_c;   x_c = val_c[0]; y_c = val_c[1]; z_c = val_c[2];
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_q <= w_c;
			x_q <= x_c;
			y_q <= y_c;
			z_q <= z_c;
		end
	end

	assign quat.valid  = vld_q;
	assign quat.quat_w = w_q;
	assign quat.quat_x = x_q;
	assign quat.quat_y = y_q;
	assign quat.quat_z = z_q;

endmodule

### rtl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion unit, bound to the top.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_unit.
module rmq_checker import rmq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input fix_t quat_w,
	input fix_t quat_x,
	input fix_t quat_y,
	input fix_t quat_z
);

	// A stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
			&& $stable(quat_y) && $stable(quat_z))
		else $error("quat result changed while stalled");

	// Input is ready exactly when the output slot is free or draining
	a_in_ready: assert property (@(posedge clk)
		in_ready == (!out_valid || out_ready))
		else $error("mat.ready does not follow output slot");

	// No result right after reset release
	a_rst_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("quat.valid high right after reset");

	// A shown result carries known values on every component
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({quat_w, quat_x, quat_y, quat_z}))
		else $error("quat result has unknown bits");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (mat.valid),
	.in_ready  (mat.ready),
	.out_valid (quat.valid),
	.out_ready (quat.ready),
	.quat_w    (quat.quat_w),
	.quat_x    (quat.quat_x),
	.quat_y    (quat.quat_y),
	.quat_z    (quat.quat_z)
);
